FILE: src/mpf_pkg.sv
// Shared constants, command codes and job types of the monochrome page frame buffer.
`timescale 1ns / 1ps

package mpf_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    localparam int CMD_W      = 3;
    localparam int POS_W      = 10;
    localparam int AREA_W_W   = 8;
    localparam int AREA_H_W   = 7;
    localparam int PAGE_IDX_W = 3;
    localparam int BYTE_W     = 8;

    // Internal field widths sized for the largest screen: 256 columns, 16 pages, 128 rows.
    localparam int COL_W  = 8;
    localparam int PAGE_W = 4;
    localparam int ROW_W  = 8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_SET_PIXEL   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET_PIXEL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FILL_ALL    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INVERT_ALL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_AREA_FILL   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_AREA_CLEAR  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_AREA_INVERT = 3'd6;
    localparam logic [CMD_W-1:0] CMD_READ_BYTE   = 3'd7;

    localparam logic [1:0] JOB_NONE = 2'd0;
    localparam logic [1:0] JOB_RMW  = 2'd1;
    localparam logic [1:0] JOB_FILL = 2'd2;

    localparam logic [1:0] WR_KEEP   = 2'd0;
    localparam logic [1:0] WR_DATA   = 2'd1;
    localparam logic [1:0] WR_INVERT = 2'd2;

    localparam logic [1:0] RSP_NONE  = 2'd0;
    localparam logic [1:0] RSP_PIXEL = 2'd1;
    localparam logic [1:0] RSP_BYTE  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        wr_mode;
        logic [1:0]        rsp_sel;
        logic              accepted;
        logic [PAGE_W-1:0] page_lo;
        logic [PAGE_W-1:0] page_hi;
        logic [COL_W-1:0]  col_lo;
        logic [COL_W-1:0]  col_hi;
        logic [ROW_W-2:0]  row_lo;
        logic [ROW_W-1:0]  row_hi;
        logic              full_mask;
        logic [BYTE_W-1:0] data;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_req;

endpackage

FILE: src/mpf_if.sv
// Request and result channel interfaces of the monochrome page frame buffer.
`timescale 1ns / 1ps

interface mpf_req_if;
    import mpf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [AREA_W_W-1:0]     area_width;
    logic [AREA_H_W-1:0]     area_height;
    logic                    pixel_value;
    logic [BYTE_W-1:0]       fill_byte;
    logic [PAGE_IDX_W-1:0]   page_index;

    modport source (
        output valid, cmd, pos_x, pos_y, area_width, area_height, pixel_value, fill_byte,
               page_index,
        input  ready
    );

    modport sink (
        input  valid, cmd, pos_x, pos_y, area_width, area_height, pixel_value, fill_byte,
               page_index,
        output ready
    );
endinterface

interface mpf_rsp_if;
    import mpf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              pixel_out;
    logic              accepted;

    modport source (
        output valid, read_data, pixel_out, accepted,
        input  ready
    );

    modport sink (
        input  valid, read_data, pixel_out, accepted,
        output ready
    );
endinterface

FILE: src/mpf_front.sv
// Front end: range-checks each request and turns it into a store walk job.
`timescale 1ns / 1ps

module mpf_front #(
    parameter int SCREEN_WIDTH  = mpf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mpf_pkg::SCREEN_HEIGHT_DEF
) (
    mpf_req_if.sink          i_req,
    input  logic             i_queue_ready,
    input  logic             i_clear_done,
    output mpf_pkg::t_job_req o_push
);
    import mpf_pkg::*;

    localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
    localparam logic [POS_W-1:0]  WIDTH_L   = POS_W'(SCREEN_WIDTH);
    localparam logic [POS_W-1:0]  HEIGHT_L  = POS_W'(SCREEN_HEIGHT);
    localparam logic [ROW_W:0]    HEIGHT_R  = (ROW_W + 1)'(SCREEN_HEIGHT);
    localparam logic [PAGE_W:0]   PAGES_L   = (PAGE_W + 1)'(PAGE_COUNT);
    localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_WIDTH - 1);

    logic [POS_W-1:0]    px_u;
    logic [POS_W-1:0]    py_u;
    logic                x_on;
    logic                y_on;
    logic [POS_W-1:0]    x_end;
    logic [POS_W-1:0]    y_end;
    logic                area_ok;
    logic                area_empty;
    logic                page_ok;
    logic [ROW_W-1:0]    h_round;
    logic [ROW_W:0]      band_end;
    logic [ROW_W-1:0]    band_hi;
    logic [ROW_W-1:0]    band_hi_m1;
    logic [2*BYTE_W-1:0] fill_rot;
    t_job                job;

    assign px_u = i_req.pos_x;
    assign py_u = i_req.pos_y;

    assign x_on  = !px_u[POS_W-1] && (px_u < WIDTH_L);
    assign y_on  = !py_u[POS_W-1] && (py_u < HEIGHT_L);
    assign x_end = px_u + POS_W'(i_req.area_width);
    assign y_end = py_u + POS_W'(i_req.area_height);

    assign area_ok    = x_on && y_on && (x_end <= WIDTH_L) && (y_end <= HEIGHT_L);
    assign area_empty = (i_req.area_width == '0) || (i_req.area_height == '0);
    assign page_ok    = (PAGE_W + 1)'(i_req.page_index) < PAGES_L;

    // Round the height up to whole bands, then clip at the bottom edge.
    assign h_round    = ROW_W'(i_req.area_height) + ROW_W'(7);
    assign band_end   = (ROW_W + 1)'(py_u[ROW_W-2:0])
                      + (ROW_W + 1)'({h_round[ROW_W-1:3], 3'b000});
    assign band_hi    = (band_end > HEIGHT_R) ? HEIGHT_R[ROW_W-1:0] : band_end[ROW_W-1:0];
    assign band_hi_m1 = band_hi - ROW_W'(1);

    // Row band+i takes bit i: rotate the pattern onto the page bit positions.
    assign fill_rot = {i_req.fill_byte, i_req.fill_byte} << py_u[2:0];

    always_comb begin
        job.kind      = JOB_NONE;
        job.wr_mode   = WR_KEEP;
        job.rsp_sel   = RSP_NONE;
        job.accepted  = 1'b0;
        job.page_lo   = py_u[ROW_W-2:3];
        job.page_hi   = py_u[ROW_W-2:3];
        job.col_lo    = px_u[COL_W-1:0];
        job.col_hi    = px_u[COL_W-1:0];
        job.row_lo    = py_u[ROW_W-2:0];
        job.row_hi    = ROW_W'(py_u[ROW_W-2:0]) + ROW_W'(1);
        job.full_mask = 1'b0;
        job.data      = '0;
        unique case (i_req.cmd)
            CMD_SET_PIXEL: begin
                job.accepted = x_on && y_on;
                job.kind     = (x_on && y_on) ? JOB_RMW : JOB_NONE;
                job.wr_mode  = WR_DATA;
                job.data     = {BYTE_W{i_req.pixel_value}};
            end
            CMD_GET_PIXEL: begin
                job.accepted = x_on && y_on;
                job.kind     = (x_on && y_on) ? JOB_RMW : JOB_NONE;
                job.rsp_sel  = (x_on && y_on) ? RSP_PIXEL : RSP_NONE;
            end
            CMD_FILL_ALL: begin
                job.accepted  = 1'b1;
                job.kind      = JOB_FILL;
                job.wr_mode   = WR_DATA;
                job.page_lo   = '0;
                job.page_hi   = LAST_PAGE;
                job.col_lo    = '0;
                job.col_hi    = LAST_COL;
                job.full_mask = 1'b1;
                job.data      = i_req.fill_byte;
            end
            CMD_INVERT_ALL: begin
                job.accepted  = 1'b1;
                job.kind      = JOB_RMW;
                job.wr_mode   = WR_INVERT;
                job.page_lo   = '0;
                job.page_hi   = LAST_PAGE;
                job.col_lo    = '0;
                job.col_hi    = LAST_COL;
                job.full_mask = 1'b1;
            end
            CMD_AREA_FILL, CMD_AREA_CLEAR, CMD_AREA_INVERT: begin
                job.accepted = area_ok;
                job.kind     = (area_ok && !area_empty) ? JOB_RMW : JOB_NONE;
                job.page_hi  = band_hi_m1[ROW_W-2:3];
                job.col_hi   = px_u[COL_W-1:0] + COL_W'(i_req.area_width) - COL_W'(1);
                job.row_hi   = band_hi;
                if (i_req.cmd == CMD_AREA_FILL) begin
                    job.wr_mode = WR_DATA;
                    job.data    = fill_rot[2*BYTE_W-1:BYTE_W];
                end else if (i_req.cmd == CMD_AREA_CLEAR) begin
                    job.wr_mode = WR_DATA;
                end else begin
                    job.wr_mode = WR_INVERT;
                end
            end
            CMD_READ_BYTE: begin
                job.accepted  = x_on && page_ok;
                job.kind      = (x_on && page_ok) ? JOB_RMW : JOB_NONE;
                job.rsp_sel   = (x_on && page_ok) ? RSP_BYTE : RSP_NONE;
                job.page_lo   = PAGE_W'(i_req.page_index);
                job.page_hi   = PAGE_W'(i_req.page_index);
                job.full_mask = 1'b1;
            end
        endcase
    end

    assign i_req.ready  = i_queue_ready && i_clear_done;
    assign o_push.valid = i_req.valid && i_req.ready;
    assign o_push.job   = job;

endmodule

FILE: src/mpf_queue.sv
// Short job queue between the front end and the store engine.
`timescale 1ns / 1ps

module mpf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpf_pkg::t_job_req i_push,
    output logic              o_push_ready,
    output mpf_pkg::t_job_req o_head,
    input  logic              i_pop
);
    import mpf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    t_job             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign do_push      = i_push.valid && o_push_ready;
    assign do_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.job;
        end
    end

endmodule

FILE: src/mpf_back.sv
// Store engine: holds the frame memory, walks jobs over it and registers the result.
`timescale 1ns / 1ps

module mpf_back #(
    parameter int SCREEN_WIDTH  = mpf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mpf_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpf_pkg::t_job_req i_head,
    output logic              o_pop,
    output logic              o_clear_done,
    mpf_rsp_if.source         o_rsp
);
    import mpf_pkg::*;

    localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH      = PAGE_COUNT * SCREEN_WIDTH;
    localparam int AW         = $clog2(DEPTH);
    localparam int AFULL_W    = PAGE_W + COL_W;
    localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_WIDTH - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_FILL  = 3'd4;
    localparam logic [2:0] ST_RESP  = 3'd5;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    t_job               r_job;
    logic [PAGE_W-1:0]  r_page;
    logic [PAGE_W-1:0]  n_page;
    logic [COL_W-1:0]   r_col;
    logic [COL_W-1:0]   n_col;
    logic [BYTE_W-1:0]  r_mem [DEPTH];
    logic [BYTE_W-1:0]  r_rd_data;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_pix;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_data;
    logic               r_out_pix;
    logic               r_out_acc;
    logic [AFULL_W-1:0] addr_full;
    logic [AW-1:0]      addr;
    logic [PAGE_W-1:0]  page_hi;
    logic [COL_W-1:0]   col_lo;
    logic [COL_W-1:0]   col_hi;
    logic               col_wrap;
    logic               walk_last;
    logic [BYTE_W-1:0]  mask;
    logic [BYTE_W-1:0]  wr_data;
    logic               wr_en;
    logic               out_free;
    logic               load_out;

    assign addr_full = AFULL_W'(r_page) * AFULL_W'(SCREEN_WIDTH) + AFULL_W'(r_col);
    assign addr      = AW'(addr_full);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            page_hi = LAST_PAGE;
            col_lo  = '0;
            col_hi  = LAST_COL;
        end else begin
            page_hi = r_job.page_hi;
            col_lo  = r_job.col_lo;
            col_hi  = r_job.col_hi;
        end
    end

    assign col_wrap  = (r_col == col_hi);
    assign walk_last = col_wrap && (r_page == page_hi);
    assign n_col     = col_wrap ? col_lo : r_col + COL_W'(1);
    assign n_page    = col_wrap ? r_page + PAGE_W'(1) : r_page;

    // Select the rows of the current page that fall inside the band range.
    always_comb begin
        logic [ROW_W-2:0] row;
        for (int b = 0; b < BYTE_W; b++) begin
            row     = {r_page, 3'(b)};
            mask[b] = r_job.full_mask
                   || ((row >= r_job.row_lo) && (ROW_W'(row) < r_job.row_hi));
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_data = r_job.data;
        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = '0;
            end
            ST_FILL: begin
                wr_en = 1'b1;
            end
            ST_MOD: begin
                case (r_job.wr_mode)
                    WR_DATA: begin
                        wr_en   = 1'b1;
                        wr_data = (r_rd_data & ~mask) | (r_job.data & mask);
                    end
                    WR_INVERT: begin
                        wr_en   = 1'b1;
                        wr_data = r_rd_data ^ mask;
                    end
                    default: begin
                        wr_en = 1'b0;
                    end
                endcase
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign out_free     = !r_out_valid || o_rsp.ready;
    assign load_out     = (r_state == ST_RESP) && out_free;
    assign o_pop        = (r_state == ST_IDLE) && i_head.valid;
    assign o_clear_done = (r_state != ST_CLEAR);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (walk_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.job.kind == JOB_RMW) begin
                        n_state = ST_READ;
                    end else if (i_head.job.kind == JOB_FILL) begin
                        n_state = ST_FILL;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_MOD;
            end
            ST_MOD: begin
                n_state = walk_last ? ST_RESP : ST_READ;
            end
            ST_FILL: begin
                if (walk_last) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_page      <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= load_out || (r_out_valid && !o_rsp.ready);
            if (o_pop) begin
                r_page <= i_head.job.page_lo;
                r_col  <= i_head.job.col_lo;
            end else if (r_state == ST_CLEAR || r_state == ST_FILL || r_state == ST_MOD) begin
                r_page <= n_page;
                r_col  <= n_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[addr] <= wr_data;
        end
        r_rd_data <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head.job;
        end
        if (r_state == ST_MOD) begin
            r_pix  <= |(r_rd_data & mask);
            r_byte <= r_rd_data;
        end
        if (load_out) begin
            r_out_acc  <= r_job.accepted;
            r_out_pix  <= (r_job.rsp_sel == RSP_PIXEL) ? r_pix : 1'b0;
            r_out_data <= (r_job.rsp_sel == RSP_BYTE) ? r_byte : '0;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;
    assign o_rsp.pixel_out = r_out_pix;
    assign o_rsp.accepted  = r_out_acc;

endmodule

FILE: src/mono_page_framebuffer_top.sv
// Top level of the monochrome page frame buffer: one result per request.
//
//   channel | side | handshake     | payload
//   i_req   | in   | valid / ready | cmd pos_x pos_y area_width area_height pixel_value
//           |      |               | fill_byte page_index
//   o_rsp   | out  | valid / ready | read_data pixel_out accepted
//
// After reset the frame memory is zeroed one byte a cycle over all PAGE_COUNT * SCREEN_WIDTH
// bytes (1024 at 128x64); i_req.ready stays low for that pass.
// A request is checked on entry and queued (two entries); the engine then goes from idle
// straight to the result for a rejected or empty request, writes each byte for fill_all,
// and passes each byte through a read and a modify state for a pixel or byte access,
// invert_all and an area request, since the frame memory is single-port.
// A result waits in the output register while the next request runs; the engine holds
// only when a second result is ready before the first is taken.
`timescale 1ns / 1ps

module mono_page_framebuffer_top #(
    parameter int SCREEN_WIDTH  = mpf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mpf_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpf_req_if.sink   i_req,
    mpf_rsp_if.source o_rsp
);
    import mpf_pkg::*;

    t_job_req push;
    t_job_req head;
    logic     queue_ready;
    logic     pop;
    logic     clear_done;

    mpf_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_req         (i_req),
        .i_queue_ready (queue_ready),
        .i_clear_done  (clear_done),
        .o_push        (push)
    );

    mpf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (queue_ready),
        .o_head       (head),
        .i_pop        (pop)
    );

    mpf_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_clear_done (clear_done),
        .o_rsp        (o_rsp)
    );

`ifndef SYNTHESIS
    a_reset_starts_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req.ready)
        else $error("request port open right after reset");

    a_clear_runs_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear_done |=> clear_done)
        else $error("clearing pass restarted without reset");

    a_data_only_when_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.pixel_out || (o_rsp.read_data != '0))) |-> o_rsp.accepted)
        else $error("read data returned for a rejected request");
`endif

endmodule

FILE: test/mpf_frame_checker.sv
// Result checker for the monochrome page frame buffer: mirrors the frame store and compares results.
`timescale 1ns / 1ps

module mpf_frame_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mpf_req_if   i_req,
    mpf_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_result_count,
    output int   o_reject_count
);
    import mpf_pkg::*;

    localparam int COLS        = SCREEN_WIDTH_DEF;
    localparam int ROWS        = SCREEN_HEIGHT_DEF;
    localparam int PAGES       = (ROWS + 7) / 8;
    localparam int STORE_BYTES = PAGES * COLS;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              pixel_out;
        logic              accepted;
    } t_frame_result;

    logic [BYTE_W-1:0] frame_copy [STORE_BYTES];
    t_frame_result     expected_results [$];
    t_frame_result     got;
    t_frame_result     want;
    int                fail_count    = 0;
    int                result_count  = 0;
    int                reject_count  = 0;
    int                pending_count = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending_count;
    assign o_result_count = result_count;
    assign o_reject_count = reject_count;

    function automatic bit on_screen(int x, int y);
        return x >= 0 && x < COLS && y >= 0 && y < ROWS;
    endfunction

    function automatic void write_bit(int x, int row, logic v);
        int                addr;
        logic [BYTE_W-1:0] mask;
        addr = (row / 8) * COLS + x;
        mask = 8'h01 << (row % 8);
        frame_copy[addr] = v ? (frame_copy[addr] | mask) : (frame_copy[addr] & ~mask);
    endfunction

    function automatic logic read_bit(int x, int row);
        return frame_copy[(row / 8) * COLS + x][row % 8];
    endfunction

    function automatic logic walk_area(logic [CMD_W-1:0] cmd, int x0, int y0, int w, int h,
                                       logic [BYTE_W-1:0] pattern);
        int y;
        int x;
        int i;
        if (!(x0 >= 0 && x0 < COLS && x0 + w <= COLS && y0 >= 0 && y0 < ROWS &&
              y0 + h <= ROWS))
            return 1'b0;
        // walk whole 8-row bands, drop rows below the screen
        for (y = y0; y < y0 + h; y += 8) begin
            for (x = x0; x < x0 + w; x++) begin
                for (i = 0; i < 8; i++) begin
                    if (y + i < ROWS) begin
                        case (cmd)
                            CMD_AREA_FILL:  write_bit(x, y + i, pattern[i]);
                            CMD_AREA_CLEAR: write_bit(x, y + i, 1'b0);
                            default:        write_bit(x, y + i, ~read_bit(x, y + i));
                        endcase
                    end
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic t_frame_result predict_result(logic [CMD_W-1:0] cmd, int x, int y,
                                                     int w, int h, logic pv,
                                                     logic [BYTE_W-1:0] fb, int pg);
        t_frame_result r;
        r = '0;
        case (cmd)
            CMD_SET_PIXEL: begin
                if (on_screen(x, y)) begin
                    write_bit(x, y, pv);
                    r.accepted = 1'b1;
                end
            end
            CMD_GET_PIXEL: begin
                if (on_screen(x, y)) begin
                    r.pixel_out = read_bit(x, y);
                    r.accepted  = 1'b1;
                end
            end
            CMD_FILL_ALL: begin
                foreach (frame_copy[k]) frame_copy[k] = fb;
                r.accepted = 1'b1;
            end
            CMD_INVERT_ALL: begin
                foreach (frame_copy[k]) frame_copy[k] = ~frame_copy[k];
                r.accepted = 1'b1;
            end
            CMD_AREA_FILL, CMD_AREA_CLEAR, CMD_AREA_INVERT: begin
                r.accepted = walk_area(cmd, x, y, w, h, fb);
            end
            default: begin
                if (x >= 0 && x < COLS && pg < PAGES) begin
                    r.read_data = frame_copy[pg * COLS + x];
                    r.accepted  = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [BYTE_W-1:0] want_v,
                                        logic [BYTE_W-1:0] got_v);
        if (got_v !== want_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (frame_copy[k]) frame_copy[k] = '0;
            expected_results.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.read_data = i_rsp.read_data;
                got.pixel_out = i_rsp.pixel_out;
                got.accepted  = i_rsp.accepted;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %0h/%0b/%0b",
                             $time, got.read_data, got.pixel_out, got.accepted);
                end else begin
                    want = expected_results.pop_front();
                    result_count++;
                    if (!want.accepted)
                        reject_count++;
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("pixel_out", BYTE_W'(want.pixel_out), BYTE_W'(got.pixel_out));
                    check_field("accepted", BYTE_W'(want.accepted), BYTE_W'(got.accepted));
                end
            end
            if (i_req.valid && i_req.ready)
                expected_results.push_back(predict_result(i_req.cmd, int'(i_req.pos_x),
                    int'(i_req.pos_y), int'(i_req.area_width), int'(i_req.area_height),
                    i_req.pixel_value, i_req.fill_byte, int'(i_req.page_index)));
        end
        pending_count = expected_results.size();
    end

endmodule

FILE: test/mono_page_framebuffer_top_tb.sv
// Testbench top of the monochrome page frame buffer: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module mono_page_framebuffer_top_tb;
    import mpf_pkg::*;

    localparam int RANDOM_ITEMS     = 900;
    localparam int QUIET_TAIL       = 60;
    localparam int HOLD_AT          = 300;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   idle_on = 1'b1;
    bit   quiet   = 1'b0;
    bit   hold_now = 1'b0;
    int   fail_count;
    int   pending;
    int   result_count;
    int   reject_count;

    mpf_req_if req_ch ();
    mpf_rsp_if rsp_ch ();

    mono_page_framebuffer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    mpf_frame_checker frame_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req_ch),
        .i_rsp          (rsp_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_reject_count (reject_count)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #(8_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : result_sink
        bit held = 1'b0;
        forever begin
            if (hold_now && !held) begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic issue(input logic [CMD_W-1:0] cmd, input int x, input int y, input int w,
                         input int h, input logic pv, input logic [BYTE_W-1:0] fb,
                         input logic [PAGE_IDX_W-1:0] pg);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= cmd;
        req_ch.pos_x       <= x[POS_W-1:0];
        req_ch.pos_y       <= y[POS_W-1:0];
        req_ch.area_width  <= w[AREA_W_W-1:0];
        req_ch.area_height <= h[AREA_H_W-1:0];
        req_ch.pixel_value <= pv;
        req_ch.fill_byte   <= fb;
        req_ch.page_index  <= pg;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    function automatic int pick_coord(int span);
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(0, 1023)) - 512;
        return int'($urandom_range(0, span - 1));
    endfunction

    function automatic int pick_extent(int pos, int span, int field_max);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return int'($urandom_range(0, field_max));
        if (r < 4 && pos >= 0 && pos < span)
            return span - pos;
        if (r < 6 && pos >= 0 && pos < span)
            return span - pos + 1;
        return int'($urandom_range(0, 16));
    endfunction

    task automatic random_request();
        int               r;
        int               x;
        int               y;
        logic [CMD_W-1:0] cmd;
        r = $urandom_range(0, 99);
        x = pick_coord(SCREEN_WIDTH_DEF);
        y = pick_coord(SCREEN_HEIGHT_DEF);
        if (r < 22)
            cmd = CMD_SET_PIXEL;
        else if (r < 40)
            cmd = CMD_GET_PIXEL;
        else if (r < 60)
            cmd = CMD_READ_BYTE;
        else if (r < 62)
            cmd = CMD_FILL_ALL;
        else if (r < 64)
            cmd = CMD_INVERT_ALL;
        else if (r < 74)
            cmd = CMD_AREA_FILL;
        else if (r < 84)
            cmd = CMD_AREA_CLEAR;
        else if (r < 96)
            cmd = CMD_AREA_INVERT;
        else begin
            cmd = CMD_W'($urandom_range(0, 7));
            x   = int'($urandom_range(0, 1023)) - 512;
            y   = int'($urandom_range(0, 1023)) - 512;
        end
        issue(cmd, x, y, pick_extent(x, SCREEN_WIDTH_DEF, 255),
              pick_extent(y, SCREEN_HEIGHT_DEF, 127), 1'($urandom_range(0, 1)),
              BYTE_W'($urandom_range(0, 255)), PAGE_IDX_W'($urandom_range(0, 7)));
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.cmd         <= CMD_SET_PIXEL;
        req_ch.pos_x       <= '0;
        req_ch.pos_y       <= '0;
        req_ch.area_width  <= '0;
        req_ch.area_height <= '0;
        req_ch.pixel_value <= 1'b0;
        req_ch.fill_byte   <= '0;
        req_ch.page_index  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(CMD_GET_PIXEL, 0, 0, 0, 0, 1'b0, 8'h00, 3'd0);
        issue(CMD_SET_PIXEL, 0, 0, 0, 0, 1'b1, 8'h00, 3'd0);
        issue(CMD_SET_PIXEL, 127, 63, 0, 0, 1'b1, 8'h00, 3'd0);
        issue(CMD_GET_PIXEL, 127, 63, 0, 0, 1'b0, 8'h00, 3'd0);
        issue(CMD_SET_PIXEL, -1, 0, 0, 0, 1'b1, 8'h00, 3'd0);
        issue(CMD_SET_PIXEL, 128, 5, 0, 0, 1'b1, 8'h00, 3'd0);
        issue(CMD_SET_PIXEL, 3, 64, 0, 0, 1'b1, 8'h00, 3'd0);
        issue(CMD_SET_PIXEL, -512, 511, 0, 0, 1'b1, 8'h00, 3'd0);
        issue(CMD_GET_PIXEL, 128, 63, 0, 0, 1'b0, 8'h00, 3'd0);
        issue(CMD_READ_BYTE, 127, 0, 0, 0, 1'b0, 8'h00, 3'd7);
        issue(CMD_READ_BYTE, -1, 0, 0, 0, 1'b0, 8'h00, 3'd0);
        issue(CMD_READ_BYTE, 128, 0, 0, 0, 1'b0, 8'h00, 3'd3);
        issue(CMD_FILL_ALL, 0, 0, 0, 0, 1'b0, 8'hA5, 3'd0);
        issue(CMD_READ_BYTE, 5, 0, 0, 0, 1'b0, 8'h00, 3'd3);
        issue(CMD_INVERT_ALL, 0, 0, 0, 0, 1'b0, 8'h00, 3'd0);
        issue(CMD_AREA_FILL, 10, 3, 5, 10, 1'b0, 8'h3C, 3'd0);
        issue(CMD_READ_BYTE, 12, 0, 0, 0, 1'b0, 8'h00, 3'd2);
        issue(CMD_AREA_CLEAR, 0, 60, 8, 4, 1'b0, 8'h00, 3'd0);
        issue(CMD_AREA_INVERT, 120, 0, 8, 64, 1'b0, 8'h00, 3'd0);
        issue(CMD_AREA_FILL, 5, 5, 0, 8, 1'b0, 8'hFF, 3'd0);
        issue(CMD_AREA_CLEAR, 5, 5, 8, 0, 1'b0, 8'h00, 3'd0);
        issue(CMD_AREA_INVERT, 121, 0, 8, 1, 1'b0, 8'h00, 3'd0);
        issue(CMD_AREA_FILL, 0, 60, 1, 5, 1'b0, 8'hFF, 3'd0);
        issue(CMD_AREA_CLEAR, -1, 0, 1, 1, 1'b0, 8'h00, 3'd0);
        issue(CMD_AREA_INVERT, 0, 64, 1, 1, 1'b0, 8'h00, 3'd0);
        issue(CMD_AREA_FILL, 0, 0, 128, 64, 1'b0, 8'h81, 3'd0);
        issue(CMD_SET_PIXEL, 0, 0, 0, 0, 1'b0, 8'h00, 3'd0);
        issue(CMD_READ_BYTE, 0, 0, 0, 0, 1'b0, 8'h00, 3'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT)
                hold_now = 1'b1;
            if (n == RANDOM_ITEMS - QUIET_TAIL) begin
                idle_on = 1'b0;
                quiet   = 1'b1;
            end
            random_request();
        end
        req_ch.valid <= 1'b0;

        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results over all eight commands, %0d of them rejected.",
                 result_count, reject_count);
        $display("Included edge, clipping and empty-area cases and a %0d-cycle output stall.",
                 LONG_HOLD_CYCLES);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
src/mpf_pkg.sv
src/mpf_if.sv
src/mpf_front.sv
src/mpf_queue.sv
src/mpf_back.sv
src/mono_page_framebuffer_top.sv
test/mpf_frame_checker.sv
test/mono_page_framebuffer_top_tb.sv
